FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the FPop decode block.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

FILE: hdl/fpdd_pkg.sv
// Shared types, opcode tables and helper functions for the FPop decode block.
// No dependencies; used by fpdd_decode and fpop_decode_dispatch_core.
package fpdd_pkg;

  localparam int NumOps     = 36;
  localparam int FirstFpop2 = 34;

  localparam logic [31:0] OP_MASK  = 32'hc1f8_0000;
  localparam logic [31:0] OP_FPOP1 = 32'h81a0_0000;
  localparam logic [31:0] OP_FPOP2 = 32'h81a8_0000;

  localparam logic [3:0] TT_NONE    = 4'd0;
  localparam logic [3:0] TT_INVALID = 4'd6;

  // Operand size codes held in the descriptor.
  localparam logic [1:0] SZ_NONE = 2'd0;
  localparam logic [1:0] SZ_QUAD = 2'd3;

  // Source kinds.
  localparam logic [1:0] KIND_UNUSED = 2'd0;
  localparam logic [1:0] KIND_REG    = 2'd1;
  localparam logic [1:0] KIND_ZERO   = 2'd2;

  // Half-clear requests.
  localparam logic [1:0] CLR_NONE  = 2'd0;
  localparam logic [1:0] CLR_LOWER = 2'd1;
  localparam logic [1:0] CLR_UPPER = 2'd2;

  typedef logic [2:0] marks_t;
  localparam int MarkLower  = 0;
  localparam int MarkUpper  = 1;
  localparam int MarkEnable = 2;
  localparam marks_t MARKS_LOWER  = 3'b001;
  localparam marks_t MARKS_UPPER  = 3'b010;
  localparam marks_t MARKS_ENABLE = 3'b100;

  // opf code of each operation, in dense operation order.
  localparam logic [8:0] OP_OPF [NumOps] = '{
    9'h003, 9'h007, 9'h00b, 9'h02b, 9'h043, 9'h047, 9'h04b, 9'h04f, 9'h06e,
    9'h083, 9'h08c, 9'h0c7, 9'h0cb, 9'h0cc, 9'h0cd, 9'h0ce, 9'h0d3,
    9'h029, 9'h02a, 9'h041, 9'h042, 9'h045, 9'h046, 9'h049, 9'h04a, 9'h04d,
    9'h04e, 9'h069, 9'h081, 9'h082, 9'h0c6, 9'h0c9, 9'h0d1, 9'h0d2,
    9'h053, 9'h057
  };

  // Descriptor: [1:0] rs1 size, [3:2] rs2 size, [5:4] rd size, [11:8] trap type.
  localparam logic [11:0] OP_DESC [NumOps] = '{
    12'h33c, 12'h33c, 12'h33c, 12'h33c, 12'h33f, 12'h33f, 12'h33f, 12'h33f, 12'h33a,
    12'h32c, 12'h338, 12'h31c, 12'h32c, 12'h334, 12'h334, 12'h338, 12'h31c,
    12'h214, 12'h228, 12'h215, 12'h22a, 12'h215, 12'h22a, 12'h215, 12'h22a, 12'h215,
    12'h22a, 12'h225, 12'h224, 12'h228, 12'h218, 12'h224, 12'h214, 12'h218,
    12'h30f, 12'h30f
  };

  typedef struct packed {
    logic       accept;
    logic [5:0] operation;
    logic [3:0] trap_type_out;
    logic [1:0] first_src_kind;
    logic [5:0] first_src_index;
    logic [1:0] second_src_kind;
    logic [5:0] second_src_index;
    logic       dest_is_condition;
    logic [5:0] dest_index;
    logic [1:0] clear_half;
    logic       clear_graphics_status;
  } result_t;

  // Double and quad registers move field bit 0 up to index bit 5.
  function automatic logic [5:0] map_reg(input logic [1:0] size, input logic [4:0] f);
    if (size[1]) begin
      return {f[0], f[4:1], 1'b0};
    end
    return {1'b0, f};
  endfunction

  function automatic logic quad_bad(input logic [1:0] size, input logic [4:0] f);
    return (size == SZ_QUAD) && f[1];
  endfunction

endpackage

FILE: hdl/fpop_decode_dispatch_core.sv
// Top level of the FPop decode and dispatch block: input stage, decode, result register.
// Depends on fpdd_pkg, fpdd_decode and assert_macros.svh.
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------------------
//   input   | in_valid / in_ready | instruction, trap_type_in
//   output  | out_valid/out_ready | accept, operation, trap_type_out, src/dest
//
// One word is taken and delivered per cycle while out_ready holds; a result is presented
// once its word has passed the input stage and then the result register.
// The saved marks update as a word moves from the input stage to the result
// register, so the next word decodes against the updated marks.
// While a result waits, the input stage still takes one more word.
// rst is synchronous: it empties both stages and clears the saved marks.
`include "assert_macros.svh"
module fpop_decode_dispatch_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] instruction,
  input  logic [3:0]  trap_type_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        accept,
  output logic [5:0]  operation,
  output logic [3:0]  trap_type_out,
  output logic [1:0]  first_src_kind,
  output logic [5:0]  first_src_index,
  output logic [1:0]  second_src_kind,
  output logic [5:0]  second_src_index,
  output logic        dest_is_condition,
  output logic [5:0]  dest_index,
  output logic [1:0]  clear_half,
  output logic        clear_graphics_status
);

  logic              s0_valid;
  logic [31:0]       s0_insn;
  logic [3:0]        s0_tt;
  logic              out_free;
  logic              adv;
  fpdd_pkg::marks_t  marks;
  fpdd_pkg::marks_t  marks_next;
  fpdd_pkg::result_t dec_res;
  fpdd_pkg::result_t out_res;
  logic              dest_write;
  logic              dest_saved;
  logic              refused_clean;

  assign out_free = !out_valid || out_ready;
  assign adv      = s0_valid && out_free;
  assign in_ready = !s0_valid || out_free;

  fpdd_decode u_decode (
    .instruction  (s0_insn),
    .trap_type_in (s0_tt),
    .marks        (marks),
    .res          (dec_res),
    .marks_next   (marks_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      out_valid <= 1'b0;
      marks     <= '0;
    end else begin
      if (in_ready) begin
        s0_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= s0_valid;
      end
      if (adv) begin
        marks <= marks_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_insn <= instruction;
      s0_tt   <= trap_type_in;
    end
    if (adv) begin
      out_res <= dec_res;
    end
  end

  assign accept                = out_res.accept;
  assign operation             = out_res.operation;
  assign trap_type_out         = out_res.trap_type_out;
  assign first_src_kind        = out_res.first_src_kind;
  assign first_src_index       = out_res.first_src_index;
  assign second_src_kind       = out_res.second_src_kind;
  assign second_src_index      = out_res.second_src_index;
  assign dest_is_condition     = out_res.dest_is_condition;
  assign dest_index            = out_res.dest_index;
  assign clear_half            = out_res.clear_half;
  assign clear_graphics_status = out_res.clear_graphics_status;

  assign dest_write    = adv && dec_res.accept && !dec_res.dest_is_condition;
  assign dest_saved    = dest_index[5] ? marks[fpdd_pkg::MarkUpper]
                                       : marks[fpdd_pkg::MarkLower];
  assign refused_clean = (operation == '0) && (first_src_kind == fpdd_pkg::KIND_UNUSED) &&
                         (clear_half == fpdd_pkg::CLR_NONE) && !clear_graphics_status;

  // Any saved half implies the enable mark is set.
  `ASSERT_CLK(a_marks_enable, clk, rst, (marks != '0) |-> marks[fpdd_pkg::MarkEnable])
  // After a register write moves into the result register, its half is marked saved.
  `ASSERT_CLK(a_dest_half_saved, clk, rst, dest_write |=> dest_saved)
  // A refused word carries no operation and no side effects.
  `ASSERT_CLK(a_refused_clean, clk, rst, (out_valid && !accept) |-> refused_clean)
  // An accepted word always clears the trap type.
  `ASSERT_CLK(a_accept_tt, clk, rst, (out_valid && accept) |-> (trap_type_out == fpdd_pkg::TT_NONE))
  `ASSERT_NEVER(a_clear_code, clk, rst, out_valid && (clear_half == 2'd3))

endmodule

FILE: hdl/fpdd_decode.sv
// Combinational decode of one FPop word: opcode lookup, operand mapping and marks update.
// Depends on fpdd_pkg; instantiated by fpop_decode_dispatch_core.
module fpdd_decode (
  input  logic [31:0]       instruction,
  input  logic [3:0]        trap_type_in,
  input  fpdd_pkg::marks_t  marks,
  output fpdd_pkg::result_t res,
  output fpdd_pkg::marks_t  marks_next
);

  logic        is1;
  logic        is2;
  logic        cls;
  logic [8:0]  opf;
  logic        hit;
  logic [5:0]  num;
  logic [11:0] desc;
  logic [1:0]  s1;
  logic [1:0]  s2;
  logic [1:0]  sd;
  logic [4:0]  f1;
  logic [4:0]  f2;
  logic [4:0]  fd;
  logic [5:0]  idx1;
  logic [5:0]  idx2;
  logic [5:0]  idxd;
  logic        bad;
  fpdd_pkg::marks_t cur;

  assign is1  = (instruction & fpdd_pkg::OP_MASK) == fpdd_pkg::OP_FPOP1;
  assign is2  = (instruction & fpdd_pkg::OP_MASK) == fpdd_pkg::OP_FPOP2;
  assign opf  = instruction[13:5];
  assign f1   = instruction[18:14];
  assign f2   = instruction[4:0];
  assign fd   = instruction[29:25];
  assign s1   = desc[1:0];
  assign s2   = desc[3:2];
  assign sd   = desc[5:4];
  assign idx1 = fpdd_pkg::map_reg(s1, f1);
  assign idx2 = fpdd_pkg::map_reg(s2, f2);
  assign idxd = fpdd_pkg::map_reg(sd, fd);
  assign bad  = fpdd_pkg::quad_bad(s1, f1) || fpdd_pkg::quad_bad(s2, f2) ||
                fpdd_pkg::quad_bad(sd, fd);

  // A first write after the enable mark was dropped starts from enable alone.
  assign cur = marks[fpdd_pkg::MarkEnable] ? marks : fpdd_pkg::MARKS_ENABLE;

  // The opf codes are unique within each class, so the compares are independent.
  always_comb begin
    hit  = 1'b0;
    num  = '0;
    desc = '0;
    cls  = 1'b0;
    for (int i = 0; i < fpdd_pkg::NumOps; i++) begin
      cls = (i < fpdd_pkg::FirstFpop2) ? is1 : is2;
      if (!hit && cls && (opf == fpdd_pkg::OP_OPF[i])) begin
        hit  = 1'b1;
        num  = 6'(i);
        desc = fpdd_pkg::OP_DESC[i];
      end
    end
  end

  always_comb begin
    res               = '0;
    res.trap_type_out = trap_type_in;
    marks_next        = marks;
    if (hit && (trap_type_in == desc[11:8])) begin
      if (bad) begin
        res.trap_type_out = fpdd_pkg::TT_INVALID;
      end else begin
        res.accept        = 1'b1;
        res.operation     = num;
        res.trap_type_out = fpdd_pkg::TT_NONE;
        if (s1 != fpdd_pkg::SZ_NONE) begin
          res.first_src_index = idx1;
          res.first_src_kind  = (idx1[5] ? marks[fpdd_pkg::MarkUpper]
                                         : marks[fpdd_pkg::MarkLower])
                                ? fpdd_pkg::KIND_REG : fpdd_pkg::KIND_ZERO;
        end
        if (s2 != fpdd_pkg::SZ_NONE) begin
          res.second_src_index = idx2;
          res.second_src_kind  = (idx2[5] ? marks[fpdd_pkg::MarkUpper]
                                          : marks[fpdd_pkg::MarkLower])
                                 ? fpdd_pkg::KIND_REG : fpdd_pkg::KIND_ZERO;
        end
        if (sd == fpdd_pkg::SZ_NONE) begin
          res.dest_is_condition = 1'b1;
          res.dest_index        = {4'b0000, fd[1:0]};
        end else begin
          res.dest_index            = idxd;
          res.clear_graphics_status = !marks[fpdd_pkg::MarkEnable];
          if (idxd[5]) begin
            res.clear_half = cur[fpdd_pkg::MarkUpper] ? fpdd_pkg::CLR_NONE
                                                      : fpdd_pkg::CLR_UPPER;
            marks_next     = cur | fpdd_pkg::MARKS_UPPER;
          end else begin
            res.clear_half = cur[fpdd_pkg::MarkLower] ? fpdd_pkg::CLR_NONE
                                                      : fpdd_pkg::CLR_LOWER;
            marks_next     = cur | fpdd_pkg::MARKS_LOWER;
          end
        end
      end
    end
  end

endmodule
